// File: rtl/mtg_pkg.sv
// ----------------------------------------------------------------------------
// mtg_pkg: shared types and constants of the MT19937 generator
// Holds the state-array geometry, the generator constants, the microcode
// step addresses and the control word and status structs that pass between
// the sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mtg_pkg;

	// State array geometry
	localparam int unsigned STATE_WORDS   = 624;
	localparam int unsigned MIDDLE_OFFSET = 397;
	localparam int unsigned IDX_W         = 10;
	localparam int unsigned POS_W         = 10;
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(STATE_WORDS - 1);
	localparam logic [POS_W-1:0] POS_SPENT = POS_W'(STATE_WORDS);

	// Generator constants
	localparam logic [31:0] SEED_AFTER_RESET = 32'd5489;
	localparam logic [31:0] INIT_MULT        = 32'd1812433253;
	localparam logic [31:0] MATRIX_A         = 32'h9908_B0DF;
	localparam logic [31:0] UPPER_BIT        = 32'h8000_0000;
	localparam logic [31:0] LOWER_BITS       = 32'h7FFF_FFFF;
	localparam logic [31:0] TEMPER_B         = 32'h9D2C_5680;
	localparam logic [31:0] TEMPER_C         = 32'hEFC6_0000;

	// Request codes
	localparam logic REQ_SEED = 1'b0;
	localparam logic REQ_DRAW = 1'b1;

	// Microcode step addresses
	localparam int unsigned PC_W = 4;
	localparam logic [PC_W-1:0] STEP_BOOT      = 4'd0;
	localparam logic [PC_W-1:0] STEP_IDLE      = 4'd1;
	localparam logic [PC_W-1:0] STEP_SEED_HEAD = 4'd2;
	localparam logic [PC_W-1:0] STEP_SEED_MUL  = 4'd3;
	localparam logic [PC_W-1:0] STEP_SEED_WR   = 4'd4;
	localparam logic [PC_W-1:0] STEP_SEED_END  = 4'd5;
	localparam logic [PC_W-1:0] STEP_TW_HEAD   = 4'd6;
	localparam logic [PC_W-1:0] STEP_TW_PRIME  = 4'd7;
	localparam logic [PC_W-1:0] STEP_TW_RD     = 4'd8;
	localparam logic [PC_W-1:0] STEP_TW_WR     = 4'd9;
	localparam logic [PC_W-1:0] STEP_DRAW_RD   = 4'd10;
	localparam logic [PC_W-1:0] STEP_DRAW_OUT  = 4'd11;

	typedef enum logic [2:0] {
		JMP_NEXT,
		JMP_ALWAYS,
		JMP_DISPATCH,
		JMP_LOOP,
		JMP_WAIT_OUT
	} jump_t;

	typedef enum logic [1:0] {
		SEED_HOLD,
		SEED_PORT,
		SEED_DFLT
	} seed_sel_t;

	typedef enum logic [1:0] {
		RA_ZERO,
		RA_POS,
		RA_NEXT
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_SEED,
		WR_INIT,
		WR_TWIST
	} wr_sel_t;

	typedef enum logic [1:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_ONE,
		IDX_STEP
	} idx_op_t;

	typedef enum logic [1:0] {
		POS_HOLD,
		POS_FULL,
		POS_ZERO
	} pos_op_t;

	// One microcode word
	typedef struct packed {
		jump_t           jump;
		logic [PC_W-1:0] target;
		seed_sel_t       seed_sel;
		rd_sel_t         rd_a_sel;
		logic            rd_a_en;
		logic            rd_b_en;
		logic            cur_ld;
		logic            prod_ld;
		wr_sel_t         wr_sel;
		idx_op_t         idx_op;
		pos_op_t         pos_op;
		logic            emit;
	} ctrl_t;

	// Datapath status used for jumps
	typedef struct packed {
		logic idx_last;
		logic pos_spent;
		logic out_free;
	} flags_t;

endpackage

`default_nettype wire

// File: rtl/mtg_sequencer.sv
// ----------------------------------------------------------------------------
// mtg_sequencer: microcode store and step counter
// Looks up the control word of the current step in a read-only table and
// picks the next step from the jump field and the datapath flags.
// ----------------------------------------------------------------------------
`default_nettype none

module mtg_sequencer (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      req_valid,
	input  wire logic                      req_type,
	input  wire mtg_pkg::flags_t           flags,
	output mtg_pkg::ctrl_t                 ctrl,
	output logic [mtg_pkg::PC_W-1:0]       pc
);

	logic [mtg_pkg::PC_W-1:0] pc_q;
	logic [mtg_pkg::PC_W-1:0] pc_nxt;

	// Microcode table
	function automatic mtg_pkg::ctrl_t ucode(input logic [mtg_pkg::PC_W-1:0] step);
		mtg_pkg::ctrl_t w;
		w = '0;
		case (step)
			mtg_pkg::STEP_BOOT: begin
				w.seed_sel = mtg_pkg::SEED_DFLT;
				w.jump     = mtg_pkg::JMP_ALWAYS;
				w.target   = mtg_pkg::STEP_SEED_HEAD;
			end
			mtg_pkg::STEP_IDLE: begin
				w.seed_sel = mtg_pkg::SEED_PORT;
				w.jump     = mtg_pkg::JMP_DISPATCH;
			end
			mtg_pkg::STEP_SEED_HEAD: begin
				w.wr_sel = mtg_pkg::WR_SEED;
				w.idx_op = mtg_pkg::IDX_ONE;
				w.pos_op = mtg_pkg::POS_FULL;
			end
			mtg_pkg::STEP_SEED_MUL: begin
				w.prod_ld = 1'b1;
			end
			mtg_pkg::STEP_SEED_WR: begin
				w.wr_sel = mtg_pkg::WR_INIT;
				w.idx_op = mtg_pkg::IDX_STEP;
				w.jump   = mtg_pkg::JMP_LOOP;
				w.target = mtg_pkg::STEP_SEED_MUL;
			end
			mtg_pkg::STEP_SEED_END: begin
				w.jump   = mtg_pkg::JMP_ALWAYS;
				w.target = mtg_pkg::STEP_IDLE;
			end
			mtg_pkg::STEP_TW_HEAD: begin
				w.rd_a_sel = mtg_pkg::RA_ZERO;
				w.rd_a_en  = 1'b1;
				w.idx_op   = mtg_pkg::IDX_ZERO;
				w.pos_op   = mtg_pkg::POS_ZERO;
			end
			mtg_pkg::STEP_TW_PRIME: begin
				w.cur_ld = 1'b1;
			end
			mtg_pkg::STEP_TW_RD: begin
				w.rd_a_sel = mtg_pkg::RA_NEXT;
				w.rd_a_en  = 1'b1;
				w.rd_b_en  = 1'b1;
			end
			mtg_pkg::STEP_TW_WR: begin
				w.wr_sel = mtg_pkg::WR_TWIST;
				w.cur_ld = 1'b1;
				w.idx_op = mtg_pkg::IDX_STEP;
				w.jump   = mtg_pkg::JMP_LOOP;
				w.target = mtg_pkg::STEP_TW_RD;
			end
			mtg_pkg::STEP_DRAW_RD: begin
				w.rd_a_sel = mtg_pkg::RA_POS;
				w.rd_a_en  = 1'b1;
			end
			mtg_pkg::STEP_DRAW_OUT: begin
				w.emit   = 1'b1;
				w.jump   = mtg_pkg::JMP_WAIT_OUT;
				w.target = mtg_pkg::STEP_IDLE;
			end
			default: begin
				w.jump   = mtg_pkg::JMP_ALWAYS;
				w.target = mtg_pkg::STEP_IDLE;
			end
		endcase
		return w;
	endfunction

	assign ctrl = ucode(pc_q);
	assign pc   = pc_q;

	// Pick the next step
	always_comb begin
		pc_nxt = pc_q + 1'b1;
		unique case (ctrl.jump)
			mtg_pkg::JMP_NEXT: pc_nxt = pc_q + 1'b1;
			mtg_pkg::JMP_ALWAYS: pc_nxt = ctrl.target;
			mtg_pkg::JMP_DISPATCH: begin
				if (!req_valid) begin
					pc_nxt = pc_q;
				end else if (req_type == mtg_pkg::REQ_SEED) begin
					pc_nxt = mtg_pkg::STEP_SEED_HEAD;
				end else if (flags.pos_spent) begin
					pc_nxt = mtg_pkg::STEP_TW_HEAD;
				end else begin
					pc_nxt = mtg_pkg::STEP_DRAW_RD;
				end
			end
			mtg_pkg::JMP_LOOP: pc_nxt = flags.idx_last ? pc_q + 1'b1 : ctrl.target;
			mtg_pkg::JMP_WAIT_OUT: pc_nxt = flags.out_free ? ctrl.target : pc_q;
			default: pc_nxt = mtg_pkg::STEP_IDLE;
		endcase
	end

	// Hold the step counter; reset starts the seeding pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= mtg_pkg::STEP_BOOT;
		end else begin
			pc_q <= pc_nxt;
		end
	end

endmodule

`default_nettype wire

// File: rtl/mtg_datapath.sv
// ----------------------------------------------------------------------------
// mtg_datapath: state memory, seeding and twist arithmetic, output register
// Carries out whatever the current control word asks for: one memory write,
// up to two registered reads, the seeding multiply, the twist mix and the
// tempering of a drawn word into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtg_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mtg_pkg::ctrl_t ctrl,
	input  wire logic [31:0]    seed_value,
	input  wire logic           rsp_stall,
	output mtg_pkg::flags_t     flags,
	output logic                rsp_valid,
	output logic [31:0]         random_word
);

	// State memory and its registered read data
	logic [31:0] words_q [mtg_pkg::STATE_WORDS];
	logic [31:0] rd_a_q;
	logic [31:0] rd_b_q;

	logic [mtg_pkg::IDX_W-1:0] idx_q;
	logic [mtg_pkg::POS_W-1:0] pos_q;
	logic [31:0]               seed_q;
	logic [31:0]               prev_q;
	logic [31:0]               prod_q;
	logic [31:0]               cur_q;
	logic                      rsp_valid_q;
	logic [31:0]               random_word_q;

	logic [mtg_pkg::IDX_W-1:0] next_idx;
	logic [mtg_pkg::IDX_W:0]   mid_sum;
	logic [mtg_pkg::IDX_W-1:0] mid_idx;
	logic [mtg_pkg::IDX_W-1:0] rd_a_addr;
	logic [mtg_pkg::IDX_W-1:0] wr_addr;
	logic [31:0]               wr_data;
	logic                      wr_en;
	logic [31:0]               init_word;
	logic [31:0]               mix_word;
	logic [31:0]               twist_word;
	logic                      out_free;
	logic                      emit_go;

	function automatic logic [31:0] temper(input logic [31:0] y_in);
		logic [31:0] y;
		y = y_in;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
		y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	// Neighbor and middle addresses of the word being twisted
	assign next_idx = (idx_q == mtg_pkg::IDX_LAST) ? '0 : idx_q + 1'b1;
	assign mid_sum  = {1'b0, idx_q} + (mtg_pkg::IDX_W + 1)'(mtg_pkg::MIDDLE_OFFSET);
	assign mid_idx  = (mid_sum >= (mtg_pkg::IDX_W + 1)'(mtg_pkg::STATE_WORDS)) ?
		mtg_pkg::IDX_W'(mid_sum - (mtg_pkg::IDX_W + 1)'(mtg_pkg::STATE_WORDS)) :
		mid_sum[mtg_pkg::IDX_W-1:0];

	// Read address select
	always_comb begin
		case (ctrl.rd_a_sel)
			mtg_pkg::RA_POS:  rd_a_addr = pos_q[mtg_pkg::IDX_W-1:0];
			mtg_pkg::RA_NEXT: rd_a_addr = next_idx;
			default:          rd_a_addr = '0;
		endcase
	end

	// Seeding recurrence and twist mix
	assign init_word  = prod_q + {{(32 - mtg_pkg::IDX_W){1'b0}}, idx_q};
	assign mix_word   = (cur_q & mtg_pkg::UPPER_BIT) | (rd_a_q & mtg_pkg::LOWER_BITS);
	assign twist_word = rd_b_q ^ (mix_word >> 1) ^ (mix_word[0] ? mtg_pkg::MATRIX_A : '0);

	// Write select
	always_comb begin
		wr_en   = 1'b1;
		wr_addr = idx_q;
		wr_data = init_word;
		unique case (ctrl.wr_sel)
			mtg_pkg::WR_SEED: begin
				wr_addr = '0;
				wr_data = seed_q;
			end
			mtg_pkg::WR_INIT:  wr_data = init_word;
			mtg_pkg::WR_TWIST: wr_data = twist_word;
			default:           wr_en   = 1'b0;
		endcase
	end

	// Memory access
	always_ff @(posedge clk) begin
		if (wr_en) begin
			words_q[wr_addr] <= wr_data;
		end
		if (ctrl.rd_a_en) begin
			rd_a_q <= words_q[rd_a_addr];
		end
		if (ctrl.rd_b_en) begin
			rd_b_q <= words_q[mid_idx];
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (ctrl.seed_sel)
			mtg_pkg::SEED_PORT: seed_q <= seed_value;
			mtg_pkg::SEED_DFLT: seed_q <= mtg_pkg::SEED_AFTER_RESET;
			default:            seed_q <= seed_q;
		endcase
		if (ctrl.wr_sel == mtg_pkg::WR_SEED) begin
			prev_q <= seed_q;
		end else if (ctrl.wr_sel == mtg_pkg::WR_INIT) begin
			prev_q <= init_word;
		end
		if (ctrl.prod_ld) begin
			prod_q <= mtg_pkg::INIT_MULT * (prev_q ^ (prev_q >> 30));
		end
		if (ctrl.cur_ld) begin
			cur_q <= rd_a_q;
		end
		if (emit_go) begin
			random_word_q <= temper(rd_a_q);
		end
	end

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign emit_go  = ctrl.emit && out_free;

	// Word index, read position and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			pos_q       <= mtg_pkg::POS_SPENT;
			rsp_valid_q <= 1'b0;
		end else begin
			case (ctrl.idx_op)
				mtg_pkg::IDX_ZERO: idx_q <= '0;
				mtg_pkg::IDX_ONE:  idx_q <= mtg_pkg::IDX_W'(1);
				mtg_pkg::IDX_STEP: idx_q <= next_idx;
				default:           idx_q <= idx_q;
			endcase
			if (ctrl.pos_op == mtg_pkg::POS_FULL) begin
				pos_q <= mtg_pkg::POS_SPENT;
			end else if (ctrl.pos_op == mtg_pkg::POS_ZERO) begin
				pos_q <= '0;
			end else if (emit_go) begin
				pos_q <= pos_q + 1'b1;
			end
			if (emit_go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign flags.idx_last  = (idx_q == mtg_pkg::IDX_LAST);
	assign flags.pos_spent = (pos_q >= mtg_pkg::POS_SPENT);
	assign flags.out_free  = out_free;
	assign rsp_valid       = rsp_valid_q;
	assign random_word     = random_word_q;

endmodule

`default_nettype wire

// File: rtl/mt19937_generator_unit.sv
// ----------------------------------------------------------------------------
// mt19937_generator_unit: 32-bit Mersenne Twister random word source
// Request channel: req_type selects a reseed from seed_value or a draw.
// Response channel: one tempered random_word for each draw, none for a seed.
// A request transaction completes when req_valid is high and req_stall low;
// req_stall is low only while the sequencer waits in its idle step.
// A draw with words left reads its word in the read step and loads the
// tempered response in the output step before the next request is let in.
// When the 624 words are used up the draw first twists the state, with a
// read step and a write step per word on the shared two-read, one-write
// state memory.
// A reseed writes the seed to word 0, then takes one multiply step and one
// write step per further word through the same memory.
// After reset the block seeds itself with 5489, holding req_stall high
// until that seeding pass is done.
// When the receiver stalls, the response register holds its transaction;
// reseeds are still accepted, and the next draw is accepted and waits in its
// output step until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module mt19937_generator_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic        req_type,
	input  wire logic [31:0] seed_value,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic [31:0]      random_word
);

	mtg_pkg::ctrl_t           ctrl;
	mtg_pkg::flags_t          flags;
	logic [mtg_pkg::PC_W-1:0] pc;

	mtg_sequencer u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_type),
		.flags     (flags),
		.ctrl      (ctrl),
		.pc        (pc)
	);

	mtg_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.seed_value  (seed_value),
		.rsp_stall   (rsp_stall),
		.flags       (flags),
		.rsp_valid   (rsp_valid),
		.random_word (random_word)
	);

	// Take requests only in the idle step
	assign req_stall = (pc != mtg_pkg::STEP_IDLE);

	// Every accepted request closes the request channel in the cycle after its acceptance
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request channel open right after an accepted request");

	// A response is only ever loaded from the output step, never from idle
	a_rsp_from_draw: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response appeared without a draw in progress");

	// A draw never reads past the end of the state
	a_draw_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> !flags.pos_spent)
		else $error("draw read beyond the state words");

endmodule

`default_nettype wire
